// ----- rtl/owtr_pkg.sv -----
// Package: shared types and constants of the one-wire temperature reader.
`default_nettype none
package owtr_pkg;

	localparam int unsigned CODE_BYTES = 8;
	localparam int unsigned CODE_W     = 8 * CODE_BYTES;
	localparam int unsigned TICK_W     = 20;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [7:0] CMD_READ_ROM  = 8'h33;
	localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
	localparam logic [7:0] CMD_SKIP_ROM  = 8'hcc;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_SP   = 8'hbe;
	localparam logic [7:0] CMD_SEARCH    = 8'hf0;

	localparam logic [15:0]     RST_LOW_DEF   = 16'd480;
	localparam logic [15:0]     PRES_WAIT_DEF = 16'd240;
	localparam logic [7:0]      SLOT_DEF      = 8'd60;
	localparam logic [TICK_W-1:0] CONV_DEF    = 20'd750000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESET_LOW  = 3'd0,
		CFG_PRES_WAIT  = 3'd1,
		CFG_SLOT       = 3'd2,
		CFG_CONV_WAIT  = 3'd3,
		CFG_ADDR_MODE  = 3'd4,
		CFG_ROM_CODE   = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RST_LOW   = 4'd1,
		PH_RST_WAIT  = 4'd2,
		PH_W_SKIP1   = 4'd3,
		PH_W_CONVERT = 4'd4,
		PH_CONV_WAIT = 4'd5,
		PH_RST2_LOW  = 4'd6,
		PH_RST2_WAIT = 4'd7,
		PH_W_ADDR    = 4'd8,
		PH_W_CODE    = 4'd9,
		PH_W_READSP  = 4'd10,
		PH_R_LSB     = 4'd11,
		PH_R_MSB     = 4'd12,
		PH_W_READROM = 4'd13,
		PH_R_CODE    = 4'd14,
		PH_DONE      = 4'd15
	} phase_t;

	typedef struct packed {
		logic [15:0]       reset_low_ticks;
		logic [15:0]       presence_wait_ticks;
		logic [7:0]        slot_ticks;
		logic [TICK_W-1:0] convert_wait_ticks;
		logic              address_mode;
		logic [CODE_W-1:0] rom_code;
	} cfg_t;

	typedef struct packed {
		logic bus_level;
		logic start_req;
		logic func;
	} item_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic              no_device;
		logic [CODE_W-1:0] result_value;
	} res_t;

endpackage
`default_nettype wire

// ----- rtl/owtr_cfg.sv -----
// Configuration register file of the one-wire temperature reader.
`default_nettype none
module owtr_cfg
	import owtr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CODE_W-1:0]    cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= RST_LOW_DEF;
			cfg_q.presence_wait_ticks <= PRES_WAIT_DEF;
			cfg_q.slot_ticks          <= SLOT_DEF;
			cfg_q.convert_wait_ticks  <= CONV_DEF;
			cfg_q.address_mode        <= 1'b0;
			cfg_q.rom_code            <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_RESET_LOW: cfg_q.reset_low_ticks     <= cfg_wdata[15:0];
				CFG_PRES_WAIT: cfg_q.presence_wait_ticks <= cfg_wdata[15:0];
				CFG_SLOT:      cfg_q.slot_ticks          <= cfg_wdata[7:0];
				CFG_CONV_WAIT: cfg_q.convert_wait_ticks  <= cfg_wdata[TICK_W-1:0];
				CFG_ADDR_MODE: cfg_q.address_mode        <= cfg_wdata[0];
				CFG_ROM_CODE:  cfg_q.rom_code            <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/owtr_seq.sv -----
// Bus sequencer: phase state and per-tick next-state and result logic.
`default_nettype none
module owtr_seq
	import owtr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output res_t       res
);

	phase_t            phase_q, phase_n;
	logic [TICK_W-1:0] tick_q, tick_n;
	logic [2:0]        bit_q, bit_n;
	logic [3:0]        byte_q, byte_n;
	logic [7:0]        shift_q, shift_n;
	logic [7:0]        low_q, low_n;
	logic [CODE_W-1:0] code_q, code_n;
	logic              pres_q, pres_n;
	logic              op_q, op_n;
	logic              miss_q, miss_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			low_q   <= '0;
			code_q  <= '0;
			pres_q  <= 1'b0;
			op_q    <= 1'b0;
			miss_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			low_q   <= low_n;
			code_q  <= code_n;
			pres_q  <= pres_n;
			op_q    <= op_n;
			miss_q  <= miss_n;
		end
	end

	always_comb begin
		logic [TICK_W:0]   tick_inc;
		logic [7:0]        slot;
		logic [15:0]       rst_len;
		logic [15:0]       pres_len;
		logic [TICK_W-1:0] conv_len;
		logic              wbit;
		logic              slot_end;
		logic              byte_end;
		logic              sample_at;
		logic [7:0]        rd_shift;
		logic [3:0]        byte_inc;

		phase_n = phase_q;
		tick_n  = tick_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		shift_n = shift_q;
		low_n   = low_q;
		code_n  = code_q;
		pres_n  = pres_q;
		op_n    = op_q;
		miss_n  = miss_q;
		res     = '0;
		res.busy_res = 1'b1;

		if (phase_q == PH_IDLE && item.start_req) begin
			op_n    = item.func;
			code_n  = '0;
			low_n   = '0;
			miss_n  = 1'b0;
			byte_n  = '0;
			pres_n  = 1'b0;
			phase_n = PH_RST_LOW;
			shift_n = '0;
			bit_n   = '0;
			tick_n  = '0;
		end

		slot      = (cfg.slot_ticks == '0) ? 8'd1 : cfg.slot_ticks;
		rst_len   = (cfg.reset_low_ticks == '0) ? 16'd1 : cfg.reset_low_ticks;
		pres_len  = (cfg.presence_wait_ticks == '0) ? 16'd1 : cfg.presence_wait_ticks;
		conv_len  = (cfg.convert_wait_ticks == '0) ? TICK_W'(1) : cfg.convert_wait_ticks;
		tick_inc  = {1'b0, tick_n} + 1'b1;
		wbit      = shift_n[bit_n];
		slot_end  = tick_inc >= {{(TICK_W-7){1'b0}}, slot};
		byte_end  = slot_end && (bit_n == 3'd7);
		sample_at = (slot >= 8'd2);
		rd_shift  = (tick_n == {{(TICK_W-1){1'b0}}, sample_at}) ?
			{item.bus_level, shift_n[7:1]} : shift_n;
		byte_inc  = byte_n + 4'd1;

		unique case (phase_n)
			PH_IDLE: begin
				res.busy_res = 1'b0;
			end
			PH_RST_LOW, PH_RST2_LOW: begin
				res.drive_low = 1'b1;
				if (tick_inc >= {{(TICK_W-15){1'b0}}, rst_len}) begin
					tick_n  = '0;
					pres_n  = 1'b0;
					phase_n = (phase_n == PH_RST_LOW) ? PH_RST_WAIT : PH_RST2_WAIT;
				end else begin
					tick_n = tick_inc[TICK_W-1:0];
				end
			end
			PH_RST_WAIT, PH_RST2_WAIT: begin
				if (!item.bus_level)
					pres_n = 1'b1;
				tick_n = tick_inc[TICK_W-1:0];
				if (tick_inc >= {{(TICK_W-15){1'b0}}, pres_len}) begin
					bit_n  = '0;
					tick_n = '0;
					if (phase_n == PH_RST2_WAIT) begin
						phase_n = PH_W_ADDR;
						shift_n = cfg.address_mode ? CMD_MATCH_ROM : CMD_SKIP_ROM;
					end else if (!op_n) begin
						phase_n = PH_W_SKIP1;
						shift_n = CMD_SKIP_ROM;
					end else if (!pres_n) begin
						miss_n  = 1'b1;
						code_n  = '0;
						phase_n = PH_DONE;
						shift_n = '0;
					end else begin
						byte_n  = '0;
						phase_n = PH_W_READROM;
						shift_n = CMD_READ_ROM;
					end
				end
			end
			PH_W_SKIP1, PH_W_CONVERT, PH_W_ADDR, PH_W_CODE, PH_W_READSP,
			PH_W_READROM: begin
				res.drive_low = (tick_n == '0) ||
					(!wbit && tick_inc < {{(TICK_W-7){1'b0}}, slot});
				if (slot_end) begin
					tick_n = '0;
					bit_n  = bit_n + 3'd1;
				end else begin
					tick_n = tick_inc[TICK_W-1:0];
				end
				if (byte_end) begin
					bit_n = '0;
					case (phase_n)
						PH_W_SKIP1: begin
							phase_n = PH_W_CONVERT;
							shift_n = CMD_CONVERT;
						end
						PH_W_CONVERT: begin
							phase_n = PH_CONV_WAIT;
							shift_n = '0;
						end
						PH_W_ADDR: begin
							if (shift_n == CMD_MATCH_ROM) begin
								byte_n  = '0;
								phase_n = PH_W_CODE;
								shift_n = cfg.rom_code[7:0];
							end else begin
								phase_n = PH_W_READSP;
								shift_n = CMD_READ_SP;
							end
						end
						PH_W_CODE: begin
							byte_n = byte_inc;
							if (byte_inc < 4'(CODE_BYTES)) begin
								shift_n = cfg.rom_code[{byte_inc[2:0], 3'b000} +: 8];
							end else begin
								phase_n = PH_W_READSP;
								shift_n = CMD_READ_SP;
							end
						end
						PH_W_READSP: begin
							phase_n = PH_R_LSB;
							shift_n = '0;
						end
						default: begin
							byte_n  = '0;
							phase_n = PH_R_CODE;
							shift_n = '0;
						end
					endcase
				end
			end
			PH_CONV_WAIT: begin
				if (tick_inc >= {1'b0, conv_len}) begin
					phase_n = PH_RST2_LOW;
					tick_n  = '0;
					bit_n   = '0;
					shift_n = '0;
				end else begin
					tick_n = tick_inc[TICK_W-1:0];
				end
			end
			PH_R_LSB, PH_R_MSB, PH_R_CODE: begin
				res.drive_low = (tick_n == '0);
				shift_n = rd_shift;
				if (slot_end) begin
					tick_n = '0;
					bit_n  = bit_n + 3'd1;
				end else begin
					tick_n = tick_inc[TICK_W-1:0];
				end
				if (byte_end) begin
					bit_n = '0;
					case (phase_n)
						PH_R_LSB: begin
							low_n   = rd_shift;
							phase_n = PH_R_MSB;
						end
						PH_R_MSB: begin
							code_n  = {{(CODE_W-8){1'b0}},
								{rd_shift[3:0], 4'b0000} + {4'b0000, low_n[7:4]}};
							phase_n = PH_DONE;
						end
						default: begin
							code_n[{byte_n[2:0], 3'b000} +: 8] =
								code_n[{byte_n[2:0], 3'b000} +: 8] | rd_shift;
							byte_n = byte_inc;
							if (byte_inc >= 4'(CODE_BYTES))
								phase_n = PH_DONE;
						end
					endcase
					shift_n = '0;
				end
			end
			PH_DONE: begin
				res.busy_res     = 1'b0;
				res.done_res     = 1'b1;
				res.no_device    = miss_n;
				res.result_value = miss_n ? '0 : code_n;
				phase_n          = PH_IDLE;
			end
			default: begin
				res.busy_res = 1'b0;
				phase_n      = PH_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/one_wire_temperature_reader.sv -----
// Top level of the one-wire temperature reader: input stage, sequencer, result stage.
`default_nettype none
// One-wire bus master for a temperature sensor. Each input transaction is one
// bus tick (sampled line level plus an optional start request) and yields
// exactly one result transaction with the line drive and status for that tick.
// Sustained rate is one tick per clock when out_ready does not stall; a tick
// passes the input register, then the result register, the sequencer state
// advancing as it moves across. Slot, reset and conversion timings are in ticks,
// set by the user through the register write port only while idle; not enforced.
// A temperature read returns (msb << 4) + (lsb >> 4) mod 256 in bits 7..0 of
// result_value; a device-code read returns the 64-bit code, or no_device with a
// zero value when no presence pulse was seen.
module one_wire_temperature_reader
	import owtr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic                 bus_level,
	input  wire logic                 start_req,
	input  wire logic                 func,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 drive_low,
	output      logic                 busy_res,
	output      logic                 done_res,
	output      logic                 no_device,
	output      logic [CODE_W-1:0]    result_value,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CODE_W-1:0]    cfg_wdata
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{bus_level: bus_level, start_req: start_req, func: func};
		end
	end

	owtr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	owtr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign drive_low    = res_s2.drive_low;
	assign busy_res     = res_s2.busy_res;
	assign done_res     = res_s2.done_res;
	assign no_device    = res_s2.no_device;
	assign result_value = res_s2.result_value;

endmodule
`default_nettype wire

// ----- rtl/owtr_checker.sv -----
// Port-level checker of the one-wire temperature reader and its bind.
`default_nettype none
module owtr_checker
	import owtr_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              drive_low,
	input wire logic              busy_res,
	input wire logic              done_res,
	input wire logic              no_device,
	input wire logic [CODE_W-1:0] result_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) &&
			$stable(done_res) && $stable(drive_low))
		else $error("result changed while stalled");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !drive_low)
		else $error("done with busy or drive");

	a_nodev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_device |-> done_res && result_value == '0)
		else $error("no_device without done or with value");

	a_value_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> result_value == '0 && !no_device)
		else $error("value outside done");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.drive_low    (drive_low),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.no_device    (no_device),
	.result_value (result_value)
);
`default_nettype wire
